FILE: design/fair_share_slot_scheduler_macros.svh
// assertion macros for the fair share slot scheduler
// each expects signals named clk and rst in the including scope
`ifndef FAIR_SHARE_SLOT_SCHEDULER_MACROS_SVH
`define FAIR_SHARE_SLOT_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define FSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fss assertion failed");
`define FSS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("fss forbidden condition");
`else
`define FSS_ASSERT(lbl, prop)
`define FSS_NEVER(lbl, expr)
`endif
`endif

FILE: design/fss_pkg.sv
`timescale 1ns / 1ps
package fss_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam logic [15:0] BASE_LATENCY_RESET = 16'd48;
  localparam logic [15:0] MIN_GRAN_RESET = 16'd6;

  // configuration register indexes
  localparam logic REG_BASE_LATENCY = 1'b0;
  localparam logic REG_MIN_GRAN = 1'b1;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_WAITING = 2'd1,
    ST_READY   = 2'd2,
    ST_DONE    = 2'd3
  } job_status_t;

  // what a scan pass does with each slot
  typedef enum logic [1:0] {
    MODE_MIN_PRE = 2'd0,
    MODE_WAKE    = 2'd1,
    MODE_MIN     = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic       load_en;
    logic       scan_clr;
    logic       clr_best;
    logic       scan_en;
    scan_mode_t mode;
    logic       div_clr;
    logic       div_en;
    logic       commit;
    logic       emit_idle;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/fss_ram.sv
`timescale 1ns / 1ps
module fss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fss_datapath.sv
`timescale 1ns / 1ps
module fss_datapath #(
  parameter int SLOTS = fss_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic [3:0]     slot,
  input  logic [15:0]    need,
  input  logic [31:0]    arrival,
  input  fss_pkg::cmd_t  cmd,
  output fss_pkg::stat_t stat,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [3:0]     chosen_slot,
  output logic [15:0]    slice,
  output logic [31:0]    time_now,
  output logic           idle,
  output logic           finished
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = $clog2(SLOTS + 1);

  logic [15:0] base_latency;
  logic [15:0] min_gran;
  fss_pkg::job_status_t status [SLOTS];
  logic [IW-1:0] idx;
  logic          found;
  logic [AW-1:0] best;
  logic [31:0]   best_v;
  logic [IW-1:0] count;
  logic [IW-1:0] rem;
  logic [15:0]   quo;
  logic [3:0]    div_cnt;
  logic [31:0]   cur_time;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] p;
  logic          proc;
  logic [6:0]    slot_ext;
  logic [AW-1:0] slot_addr;
  logic          load_ok;
  logic [31:0]   vrt_rdata;
  logic [31:0]   arr_rdata;
  logic [15:0]   need_rdata;
  logic          better;
  logic          wake_p;
  logic [31:0]   start_v;
  logic [15:0]   slice_floor;
  logic [15:0]   slice_c;
  logic [15:0]   need_left;
  logic [IW:0]   rem_sh;
  logic          vrt_we;
  logic [AW-1:0] vrt_waddr;
  logic [31:0]   vrt_wdata;
  logic          need_we;
  logic [AW-1:0] need_waddr;
  logic [15:0]   need_wdata;
  logic [6:0]    best_ext;

  // scan addressing: read issued at idx, data of slot idx-1 arrives now
  assign rd_addr   = cmd.scan_en ? AW'(idx) : best;
  assign p         = AW'(idx - IW'(1));
  assign proc      = cmd.scan_en && (idx != '0);
  assign slot_ext  = 7'(slot);
  assign slot_addr = slot_ext[AW-1:0];
  assign load_ok   = cmd.load_en && (slot_ext < 7'(SLOTS));
  assign best_ext  = 7'(best);

  assign better = (status[p] == fss_pkg::ST_READY) && (!found || vrt_rdata < best_v);
  assign wake_p = proc && (cmd.mode == fss_pkg::MODE_WAKE) &&
                  (status[p] == fss_pkg::ST_WAITING) && (arr_rdata <= cur_time);
  assign start_v = found ? best_v : 32'd0;

  // slice: quotient raised to granularity then cut to need
  assign slice_floor = (quo < min_gran) ? min_gran : quo;
  assign slice_c     = (slice_floor > need_rdata) ? need_rdata : slice_floor;
  assign need_left   = need_rdata - slice_c;

  // restoring divide step
  assign rem_sh = {rem, quo[15]};

  // table write ports
  always_comb begin
    vrt_we     = load_ok || wake_p || cmd.commit;
    vrt_waddr  = slot_addr;
    vrt_wdata  = 32'd0;
    need_we    = load_ok || cmd.commit;
    need_waddr = slot_addr;
    need_wdata = need;
    if (cmd.commit) begin
      vrt_waddr  = best;
      vrt_wdata  = best_v + {16'd0, slice_c};
      need_waddr = best;
      need_wdata = need_left;
    end else if (wake_p) begin
      vrt_waddr = p;
      vrt_wdata = start_v;
    end
  end

  fss_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_vrt_ram (
    .clk(clk), .we(vrt_we), .waddr(vrt_waddr), .wdata(vrt_wdata),
    .raddr(rd_addr), .rdata(vrt_rdata)
  );

  fss_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_arr_ram (
    .clk(clk), .we(load_ok), .waddr(slot_addr), .wdata(arrival),
    .raddr(rd_addr), .rdata(arr_rdata)
  );

  fss_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_need_ram (
    .clk(clk), .we(need_we), .waddr(need_waddr), .wdata(need_wdata),
    .raddr(rd_addr), .rdata(need_rdata)
  );

  assign stat.scan_last = cmd.scan_en && (idx == IW'(SLOTS));
  assign stat.found     = found;
  assign stat.div_last  = (div_cnt == 4'd15);
  assign stat.out_free  = !out_valid || out_ready;

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_latency <= fss_pkg::BASE_LATENCY_RESET;
      min_gran     <= fss_pkg::MIN_GRAN_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= fss_pkg::ST_EMPTY;
      end
      idx       <= '0;
      found     <= 1'b0;
      count     <= '0;
      div_cnt   <= '0;
      cur_time  <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      // configuration
      if (cfg_we) begin
        unique case (cfg_index)
          fss_pkg::REG_BASE_LATENCY: base_latency <= cfg_data;
          fss_pkg::REG_MIN_GRAN:     min_gran <= cfg_data;
          default: ;
        endcase
      end

      if (load_ok) begin
        status[slot_addr] <= fss_pkg::ST_WAITING;
      end

      // scan counter
      if (cmd.scan_clr) begin
        idx <= '0;
      end else if (cmd.scan_en) begin
        idx <= idx + IW'(1);
      end

      if (cmd.clr_best) begin
        found <= 1'b0;
        count <= '0;
      end else if (proc && cmd.mode != fss_pkg::MODE_WAKE) begin
        if (better) begin
          found  <= 1'b1;
          best   <= p;
          best_v <= vrt_rdata;
        end
        if (cmd.mode == fss_pkg::MODE_MIN && status[p] == fss_pkg::ST_READY) begin
          count <= count + IW'(1);
        end
      end

      if (wake_p) begin
        status[p] <= fss_pkg::ST_READY;
      end

      // divider
      if (cmd.div_clr) begin
        rem     <= '0;
        quo     <= base_latency;
        div_cnt <= '0;
      end else if (cmd.div_en) begin
        div_cnt <= div_cnt + 4'd1;
        if (rem_sh >= {1'b0, count}) begin
          rem <= IW'(rem_sh - {1'b0, count});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem_sh[IW-1:0];
          quo <= {quo[14:0], 1'b0};
        end
      end

      // result register
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        cur_time    <= cur_time + {16'd0, slice_c};
        out_valid   <= 1'b1;
        chosen_slot <= best_ext[3:0];
        slice       <= slice_c;
        time_now    <= cur_time + {16'd0, slice_c};
        idle        <= 1'b0;
        finished    <= (need_left == 16'd0);
        if (need_left == 16'd0) begin
          status[best] <= fss_pkg::ST_DONE;
        end
      end else if (cmd.emit_idle) begin
        out_valid   <= 1'b1;
        chosen_slot <= 4'd0;
        slice       <= 16'd0;
        time_now    <= 32'd0;
        idle        <= 1'b1;
        finished    <= 1'b0;
      end
    end
  end

endmodule

FILE: design/fss_ctrl.sv
`timescale 1ns / 1ps
module fss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           operation,
  output logic           in_ready,
  input  fss_pkg::stat_t stat,
  output fss_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_WAKE, S_MIN, S_DIV, S_NRD, S_COMMIT, S_EMPTY
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // commands and next state
  always_comb begin
    cmd        = '0;
    cmd.mode   = fss_pkg::MODE_MIN_PRE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && operation == fss_pkg::OP_LOAD) begin
          cmd.load_en = 1'b1;
        end else if (accept) begin
          cmd.scan_clr = 1'b1;
          cmd.clr_best = 1'b1;
          cmd.div_clr  = 1'b1;
          state_next   = S_PRE;
        end
      end
      S_PRE: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_WAKE;
        end
      end
      S_WAKE: begin
        cmd.scan_en = 1'b1;
        cmd.mode    = fss_pkg::MODE_WAKE;
        if (stat.scan_last) begin
          cmd.scan_clr = 1'b1;
          cmd.clr_best = 1'b1;
          state_next   = S_MIN;
        end
      end
      S_MIN: begin
        cmd.scan_en = 1'b1;
        cmd.mode    = fss_pkg::MODE_MIN;
        if (stat.scan_last) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.found) begin
          state_next = S_EMPTY;
        end else begin
          cmd.div_en = 1'b1;
          if (stat.div_last) begin
            state_next = S_NRD;
          end
        end
      end
      S_NRD: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_idle = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/fair_share_slot_scheduler.sv
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_ready  | operation, slot, need, arrival
// out      | output    | out_valid/out_ready| chosen_slot, slice, time_now, idle, finished
// cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// a load is written to the slot tables in the cycle it is accepted; a step runs
// three scan passes over the slot tables, one slot per cycle through the
// table read port, then a 16 step bit serial divide, a settle state and the writeback
// a step with no ready job skips the divide and emits an idle result
// reset is synchronous; all slots come up empty, time zero, no clearing pass
// a step holds before its writeback until the result register is free
module fair_share_slot_scheduler #(
  parameter int SLOTS = fss_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [3:0]  slot,
  input  logic [15:0] need,
  input  logic [31:0] arrival,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  chosen_slot,
  output logic [15:0] slice,
  output logic [31:0] time_now,
  output logic        idle,
  output logic        finished
);

`include "fair_share_slot_scheduler_macros.svh"

  fss_pkg::cmd_t  cmd;
  fss_pkg::stat_t stat;

  fss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .operation(operation),
    .in_ready(in_ready), .stat(stat), .cmd(cmd)
  );

  fss_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .slot(slot), .need(need), .arrival(arrival),
    .cmd(cmd), .stat(stat), .out_ready(out_ready), .out_valid(out_valid),
    .chosen_slot(chosen_slot), .slice(slice), .time_now(time_now),
    .idle(idle), .finished(finished)
  );

  // a step transaction keeps the input closed next cycle
  `FSS_ASSERT(a_step_busy, (in_valid && in_ready && operation == fss_pkg::OP_STEP) |=> !in_ready)
  // writeback only when the result register can take it
  `FSS_ASSERT(a_commit_free, (cmd.commit || cmd.emit_idle) |-> stat.out_free)
  // an idle result carries no grant
  `FSS_ASSERT(a_idle_zero, (out_valid && idle) |-> (slice == 16'd0 && time_now == 32'd0 && !finished))
  // commit and idle result never coincide
  `FSS_NEVER(a_one_result, cmd.commit && cmd.emit_idle)

endmodule

FILE: tb/fair_share_slot_scheduler_tb.sv
`timescale 1ns / 1ps
module fair_share_slot_scheduler_tb;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        operation;
    logic [3:0]  slot;
    logic [15:0] need;
    logic [31:0] arrival;
  } job_txn_t;

  typedef struct packed {
    logic [3:0]  chosen_slot;
    logic [15:0] slice;
    logic [31:0] time_now;
    logic        idle;
    logic        finished;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [3:0] slot = '0;
  logic [15:0] need = '0;
  logic [31:0] arrival = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] chosen_slot;
  logic [15:0] slice;
  logic [31:0] time_now;
  logic idle;
  logic finished;

  fair_share_slot_scheduler dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  fss_pkg::job_status_t sh_status [NSLOT];
  logic [15:0] sh_need [NSLOT];
  logic [31:0] sh_arrival [NSLOT];
  logic [31:0] sh_vrun [NSLOT];
  logic [31:0] sh_clock;
  logic [15:0] sh_base;
  logic [15:0] sh_gran;

  job_txn_t pending_jobs[$];
  grant_t expected_grants[$];
  int errors = 0;
  int quiet_cycles = 0;
  int hold_cycles = 0;
  bit in_taken = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int least_ready_slot();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (sh_status[i] == fss_pkg::ST_READY && (best < 0 || sh_vrun[i] < sh_vrun[best]))
        best = i;
    return best;
  endfunction

  // apply one accepted transaction to the shadow state
  task automatic schedule_job(input job_txn_t t);
    int m;
    int c;
    int count;
    logic [31:0] start;
    logic [31:0] sl;
    grant_t g;
    if (t.operation == fss_pkg::OP_LOAD) begin
      sh_status[t.slot] = fss_pkg::ST_WAITING;
      sh_need[t.slot] = t.need;
      sh_arrival[t.slot] = t.arrival;
      sh_vrun[t.slot] = '0;
      return;
    end
    m = least_ready_slot();
    start = (m < 0) ? 32'd0 : sh_vrun[m];
    for (int i = 0; i < NSLOT; i++)
      if (sh_status[i] == fss_pkg::ST_WAITING && sh_arrival[i] <= sh_clock) begin
        sh_status[i] = fss_pkg::ST_READY;
        sh_vrun[i] = start;
      end
    c = least_ready_slot();
    g = '0;
    if (c < 0) begin
      g.idle = 1'b1;
    end else begin
      count = 0;
      for (int i = 0; i < NSLOT; i++)
        if (sh_status[i] == fss_pkg::ST_READY) count++;
      sl = sh_base / count;
      if (sl < sh_gran) sl = sh_gran;
      if (sl > sh_need[c]) sl = sh_need[c];
      sh_clock += sl;
      sh_vrun[c] += sl;
      sh_need[c] -= sl[15:0];
      if (sh_need[c] == 0) sh_status[c] = fss_pkg::ST_DONE;
      g.chosen_slot = c[3:0];
      g.slice = sl[15:0];
      g.time_now = sh_clock;
      g.finished = (sh_need[c] == 0);
    end
    expected_grants.push_back(g);
  endtask

  // input transaction taken at the last rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold
      end else if (pending_jobs.size() > 0 &&
                   ($urandom_range(0, 3) != 0 || hold_cycles > 0)) begin
        in_valid <= 1'b1;
        {operation, slot, need, arrival} <= pending_jobs.pop_front();
      end else begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(5, 60)) @(negedge clk);
      end
    end
  end

  // sink with random stalls and a counted long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end
    else if ($urandom_range(0, 29) == 0) out_ready <= 1'b0;
    else if (!out_ready) out_ready <= ($urandom_range(0, 2) == 0);
    else out_ready <= 1'b1;
  end

  // monitor
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready) begin
        schedule_job({operation, slot, need, arrival});
      end
      if (out_valid && out_ready) begin
        got = {chosen_slot, slice, time_now, idle, finished};
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result", 32'(got.chosen_slot), 0);
        end else begin
          want = expected_grants.pop_front();
          if (got.chosen_slot !== want.chosen_slot)
            report_mismatch("chosen_slot", 32'(got.chosen_slot), 32'(want.chosen_slot));
          if (got.slice !== want.slice) report_mismatch("slice", 32'(got.slice), 32'(want.slice));
          if (got.time_now !== want.time_now) report_mismatch("time_now", got.time_now, want.time_now);
          if (got.idle !== want.idle) report_mismatch("idle", 32'(got.idle), 32'(want.idle));
          if (got.finished !== want.finished)
            report_mismatch("finished", 32'(got.finished), 32'(want.finished));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout");
      $display("fair_share_slot_scheduler_tb failed");
      $finish;
    end
  end

  task automatic queue_load(input logic [3:0] s, input logic [15:0] n, input logic [31:0] a);
    job_txn_t t;
    t.operation = fss_pkg::OP_LOAD;
    t.slot = s;
    t.need = n;
    t.arrival = a;
    pending_jobs.push_back(t);
  endtask

  task automatic queue_step();
    job_txn_t t;
    t.operation = fss_pkg::OP_STEP;
    t.slot = 4'($urandom);
    t.need = 16'($urandom);
    t.arrival = $urandom;
    pending_jobs.push_back(t);
  endtask

  task automatic drain();
    while (pending_jobs.size() > 0 || in_valid || expected_grants.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fss_pkg::REG_BASE_LATENCY) sh_base = val;
    else sh_gran = val;
  endtask

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0)
        queue_load(4'($urandom), ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                   16'($urandom_range(0, 120)),
                   ($urandom_range(0, 9) == 0) ? $urandom : sh_clock + $urandom_range(0, 200));
      else queue_step();
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_status[i] = fss_pkg::ST_EMPTY;
      sh_need[i] = '0;
      sh_arrival[i] = '0;
      sh_vrun[i] = '0;
    end
    sh_clock = '0;
    sh_base = fss_pkg::BASE_LATENCY_RESET;
    sh_gran = fss_pkg::MIN_GRAN_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle step, zero need, extreme slots and arrivals, overwrite
    queue_step();
    queue_load(4'd0, 16'd0, 32'd0);
    queue_load(4'd15, 16'hffff, 32'd0);
    queue_load(4'd7, 16'd20, 32'hffffffff);
    queue_step();
    queue_step();
    queue_load(4'd15, 16'd10, 32'd0);
    queue_load(4'd3, 16'd1, 32'd5);
    for (int k = 0; k < 8; k++) queue_step();
    drain();

    // zero base latency, large granularity
    write_reg(fss_pkg::REG_BASE_LATENCY, 16'd0);
    write_reg(fss_pkg::REG_MIN_GRAN, 16'hffff);
    random_phase(120);
    drain();

    // maximum base latency, zero granularity
    write_reg(fss_pkg::REG_BASE_LATENCY, 16'hffff);
    write_reg(fss_pkg::REG_MIN_GRAN, 16'd0);
    random_phase(150);
    drain();

    // sink held off while input keeps coming
    write_reg(fss_pkg::REG_BASE_LATENCY, 16'd30);
    write_reg(fss_pkg::REG_MIN_GRAN, 16'd3);
    hold_cycles = 600;
    random_phase(30);
    wait (hold_cycles == 0);
    random_phase(200);
    drain();

    write_reg(fss_pkg::REG_BASE_LATENCY, 16'($urandom_range(1, 400)));
    write_reg(fss_pkg::REG_MIN_GRAN, 16'($urandom_range(0, 20)));
    random_phase(230);
    drain();

    if (errors == 0) $display("fair_share_slot_scheduler_tb passed");
    else $display("fair_share_slot_scheduler_tb failed");
    $finish;
  end
endmodule

FILE: fair_share_slot_scheduler.f
+incdir+design
design/fss_pkg.sv
design/fss_ram.sv
design/fss_datapath.sv
design/fss_ctrl.sv
design/fair_share_slot_scheduler.sv
tb/fair_share_slot_scheduler_tb.sv
